// ===== rtl/hufd_pkg.sv =====
// Shared types and constants of the Huffman tree builder and decoder.
// Used by the cell, the cell chain and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hufd_pkg;

  localparam int MAX_SYMBOLS = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int NODE_DEPTH  = 2 * MAX_SYMBOLS - 1;
  localparam int IDX_W       = $clog2(NODE_DEPTH);
  localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
  localparam int NCNT_W      = $clog2(NODE_DEPTH + 1);
  localparam int SUM_W       = WEIGHT_BITS + $clog2(MAX_SYMBOLS);

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_BUILD  = 2'd1,
    CMD_DECODE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP2   = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  symbol;
    logic [15:0] weight;
    logic        code_bit;
    logic        last_bit;
  } in_item_t;

  typedef struct packed {
    logic       symbol_valid;
    logic [7:0] decoded_symbol;
    logic       message_end;
    logic       invalid_sequence;
    logic       build_done;
    logic [4:0] leaf_count;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [SUM_W-1:0] w;
  } entry_t;

  typedef struct packed {
    cell_op_e         op;
    logic [CNT_W-1:0] count;
    entry_t           ins;
  } chain_ctl_t;

  typedef struct packed {
    logic             leaf;
    logic [7:0]       sym;
    logic [SUM_W-1:0] w;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

endpackage
`default_nettype wire

// ===== rtl/hufd_cell.sv =====
// One slot of the weight-sorted active list.
// Depends on hufd_pkg; instantiated by hufd_chain.
`timescale 1ns / 1ps
`default_nettype none
module hufd_cell import hufd_pkg::*; (
  input  wire        clk_i,
  input  chain_ctl_t ctl_i,
  input  wire        in_list_i,
  input  entry_t     prev_i,
  input  wire        prev_go_i,
  input  entry_t     next2_i,
  output logic       go_o,
  output entry_t     entry_o
);

  entry_t entry_q, entry_d;

  // go: this slot stays ahead of an inserted entry (ties keep list order)
  assign go_o    = in_list_i && (entry_q.w <= ctl_i.ins.w);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    unique case (ctl_i.op)
      OP_INSERT: begin
        if (!go_o) begin
          entry_d = prev_go_i ? ctl_i.ins : prev_i;
        end
      end
      OP_POP2:   entry_d = next2_i;
      default:   entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
`default_nettype wire

// ===== rtl/hufd_chain.sv =====
// Row of list cells kept sorted by ascending weight; head two feed merges.
// Depends on hufd_pkg and hufd_cell.
`timescale 1ns / 1ps
`default_nettype none
module hufd_chain import hufd_pkg::*; (
  input  wire        clk_i,
  input  chain_ctl_t ctl_i,
  output entry_t     head0_o,
  output entry_t     head1_o
);

  entry_t ent [MAX_SYMBOLS];
  logic   go  [MAX_SYMBOLS];

  for (genvar i = 0; i < MAX_SYMBOLS; i++) begin : g_cell
    entry_t prev_e;
    entry_t next2_e;
    logic   prev_go;
    logic   in_list;

    if (i == 0) begin : g_first
      assign prev_e  = '0;
      assign prev_go = 1'b1;
    end else begin : g_mid
      assign prev_e  = ent[i-1];
      assign prev_go = go[i-1];
    end

    if (i + 2 < MAX_SYMBOLS) begin : g_n2
      assign next2_e = ent[i+2];
    end else begin : g_end
      assign next2_e = '0;
    end

    assign in_list = (CNT_W'(i) < ctl_i.count);

    hufd_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl_i),
      .in_list_i (in_list),
      .prev_i    (prev_e),
      .prev_go_i (prev_go),
      .next2_i   (next2_e),
      .go_o      (go[i]),
      .entry_o   (ent[i])
    );
  end

  assign head0_o = ent[0];
  assign head1_o = ent[1];

endmodule
`default_nettype wire

// ===== rtl/huffman_tree_build_and_decode.sv =====
// Huffman tree builder and bit-serial decoder. Load and clear complete in the
// idle state. A decode bit on a ready tree reads the node table twice: in the
// idle state for the current node, then in the decode state for the child it
// points to; without a ready tree it answers while idle. A build of n >= 2
// leaves runs n-1 merges: each pops the two lightest cells of the sorted chain
// in the merge state and inserts the parent in the insert state after it; a
// build of a ready tree or of fewer than two leaves answers while idle.
// Results leave through a registered output; a new item is taken once the
// controller is idle and the output register is free or draining.
// Depends on hufd_pkg and hufd_chain.
`timescale 1ns / 1ps
`default_nettype none
module huffman_tree_build_and_decode import hufd_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  wire       out_stall_i,
  output out_item_t out_data_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MERGE  = 4'b0010,
    ST_INSERT = 4'b0100,
    ST_DEC    = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [NCNT_W-1:0] ncnt_q, ncnt_d;
  logic [IDX_W-1:0]  root_q, root_d;
  logic [IDX_W-1:0]  walk_q, walk_d;
  logic              ready_q, ready_d;
  logic [IDX_W-1:0]  nxt_q, nxt_d;
  logic              last_q, last_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  node_t             nodes_q [NODE_DEPTH];
  logic              nt_we;
  logic [IDX_W-1:0]  nt_waddr;
  node_t             nt_wdata;
  node_t             nt_rdata;

  chain_ctl_t        ctl;
  entry_t            head0, head1;
  logic              accept;
  logic [NCNT_W:0]   lc_wide;

  hufd_chain u_chain (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .head0_o (head0),
    .head1_o (head1)
  );

  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign nt_rdata = nodes_q[(state_q == ST_DEC) ? nxt_q : walk_q];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ncnt_d      = ncnt_q;
    root_d      = root_q;
    walk_d      = walk_q;
    ready_d     = ready_q;
    nxt_d       = nxt_q;
    last_d      = last_q;
    sum_d       = sum_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    nt_we       = 1'b0;
    nt_waddr    = ncnt_q[IDX_W-1:0];
    nt_wdata    = '0;
    ctl.op      = OP_HOLD;
    ctl.count   = cnt_q;
    ctl.ins     = '0;
    lc_wide     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data_i.command)
            CMD_LOAD: begin
              if (!ready_q && (cnt_q < CNT_W'(MAX_SYMBOLS))
                  && (ncnt_q < NCNT_W'(NODE_DEPTH))) begin
                nt_we          = 1'b1;
                nt_wdata.leaf  = 1'b1;
                nt_wdata.sym   = in_data_i.symbol;
                nt_wdata.w     = SUM_W'(in_data_i.weight);
                ctl.op         = OP_INSERT;
                ctl.ins.idx    = ncnt_q[IDX_W-1:0];
                ctl.ins.w      = SUM_W'(in_data_i.weight);
                cnt_d          = cnt_q + 1'b1;
                ncnt_d         = ncnt_q + 1'b1;
              end
            end
            CMD_BUILD: begin
              if (ready_q) begin
                lc_wide     = {1'b0, ncnt_q} + 1'b1;
                out_d       = '0;
                out_d.build_done = 1'b1;
                out_d.leaf_count = lc_wide[5:1];
                out_valid_d = 1'b1;
              end else if (cnt_q < CNT_W'(2)) begin
                out_d       = '0;
                out_d.build_done       = 1'b1;
                out_d.invalid_sequence = 1'b1;
                out_d.leaf_count       = 5'(cnt_q);
                out_valid_d = 1'b1;
              end else begin
                state_d = ST_MERGE;
              end
            end
            CMD_DECODE: begin
              if (!ready_q) begin
                out_d       = '0;
                out_d.invalid_sequence = 1'b1;
                out_d.message_end      = in_data_i.last_bit;
                out_valid_d = 1'b1;
              end else begin
                nxt_d   = in_data_i.code_bit ? nt_rdata.right : nt_rdata.left;
                last_d  = in_data_i.last_bit;
                state_d = ST_DEC;
              end
            end
            default: begin
              cnt_d   = '0;
              ncnt_d  = '0;
              root_d  = '0;
              walk_d  = '0;
              ready_d = 1'b0;
            end
          endcase
        end
      end
      ST_MERGE: begin
        sum_d          = head0.w + head1.w;
        nt_we          = 1'b1;
        nt_wdata.leaf  = 1'b0;
        nt_wdata.w     = sum_d;
        nt_wdata.left  = head0.idx;
        nt_wdata.right = head1.idx;
        ctl.op         = OP_POP2;
        cnt_d          = cnt_q - CNT_W'(2);
        state_d        = ST_INSERT;
      end
      ST_INSERT: begin
        ctl.op      = OP_INSERT;
        ctl.ins.idx = ncnt_q[IDX_W-1:0];
        ctl.ins.w   = sum_q;
        cnt_d       = cnt_q + 1'b1;
        ncnt_d      = ncnt_q + 1'b1;
        if (cnt_q != '0) begin
          state_d = ST_MERGE;
        end else begin
          // the parent just inserted is the only entry left: it is the root
          root_d      = ncnt_q[IDX_W-1:0];
          walk_d      = ncnt_q[IDX_W-1:0];
          ready_d     = 1'b1;
          lc_wide     = {1'b0, ncnt_q} + 2'd2;
          out_d       = '0;
          out_d.build_done = 1'b1;
          out_d.leaf_count = lc_wide[5:1];
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_DEC: begin
        state_d = ST_IDLE;
        if (nt_rdata.leaf) begin
          walk_d      = root_q;
          out_d       = '0;
          out_d.symbol_valid   = 1'b1;
          out_d.decoded_symbol = nt_rdata.sym;
          out_d.message_end    = last_q;
          out_valid_d = 1'b1;
        end else if (last_q) begin
          walk_d      = root_q;
          out_d       = '0;
          out_d.message_end      = 1'b1;
          out_d.invalid_sequence = 1'b1;
          out_valid_d = 1'b1;
        end else begin
          walk_d = nxt_q;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ncnt_q      <= '0;
      root_q      <= '0;
      walk_q      <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ncnt_q      <= ncnt_d;
      root_q      <= root_d;
      walk_q      <= walk_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nxt_q  <= nxt_d;
    last_q <= last_d;
    sum_q  <= sum_d;
    out_q  <= out_d;
    if (nt_we) begin
      nodes_q[nt_waddr] <= nt_wdata;
    end
  end

  a_ready_one_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> (cnt_q == CNT_W'(1)))
    else $error("ready tree must leave exactly one list entry");

  a_merge_has_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> (cnt_q >= CNT_W'(2)))
    else $error("merge started with fewer than two entries");

  a_node_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ncnt_q <= NCNT_W'(NODE_DEPTH))
    else $error("node count beyond table depth");

  a_busy_result_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !out_valid_q)
    else $error("result pending while an item is in work");

endmodule
`default_nettype wire
